// ----- rtl/nearest_free_slot_finder_defines.svh -----
// Assertion macros for the nearest free slot finder.
`ifndef NEAREST_FREE_SLOT_FINDER_DEFINES_SVH
`define NEAREST_FREE_SLOT_FINDER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define NFSF_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("nfsf assertion failed");

// Next-cycle implication, checked out of reset.
`define NFSF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("nfsf assertion failed");

`endif

// ----- rtl/nfsf_pkg.sv -----
// Shared types and constants of the nearest free slot finder.
package nfsf_pkg;

  localparam int COLUMNS_DEF = 9;
  localparam int ROWS_DEF    = 6;

  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  localparam int PITCH_W  = 12;
  localparam int OFFSET_W = 13;
  localparam int POS_W    = 16;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_COLUMN_PITCH  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLUMN_OFFSET = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_PITCH     = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_OFFSET    = 8'd3;

  localparam logic [PITCH_W-1:0]  COLUMN_PITCH_RST  = 12'd1071;
  localparam logic [OFFSET_W-1:0] COLUMN_OFFSET_RST = 13'd1435;
  localparam logic [PITCH_W-1:0]  ROW_PITCH_RST     = 12'd1700;
  localparam logic [OFFSET_W-1:0] ROW_OFFSET_RST    = 13'd550;

  localparam logic [31:0] CENTRE_MAX = 32'd65535;

  typedef struct packed {
    logic                    request;
    logic signed [POS_W-1:0] pos_x_mm;
    logic signed [POS_W-1:0] pos_z_mm;
    logic                    commit_free;
  } in_t;

  typedef struct packed {
    logic        found;
    logic [3:0]  slot_column;
    logic [2:0]  slot_row;
    logic [5:0]  slot_index;
    logic [15:0] centre_x_mm;
    logic [15:0] centre_z_mm;
    logic [5:0]  free_count;
  } out_t;

endpackage

// ----- rtl/nfsf_ram.sv -----
// Generic simple dual-port RAM with registered read.
module nfsf_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/nearest_free_slot_finder.sv -----
// Top level: nearest free slot search over a free-slot map held in RAM.
//
//  channel  | handshake               | payload
//  ---------+-------------------------+-------------------------------------
//  input    | start / busy            | in_data  (nfsf_pkg::in_t)
//  result   | out_valid strobe        | out_data (nfsf_pkg::out_t)
//  config   | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// After reset the map RAM is swept to "free", one slot a cycle, with busy
// high. An item on a rising request reads the map once per slot, then waits
// for the read data and reports; a falling request with a latched slot reads,
// writes back and reports; any other item goes straight to the report step.
// The single RAM read port sets the scan length. The result strobe
// is one cycle wide and cannot be stalled; cfg_ready is always high.
`include "nearest_free_slot_finder_defines.svh"

module nearest_free_slot_finder #(
  parameter int COLUMNS = nfsf_pkg::COLUMNS_DEF,
  parameter int ROWS    = nfsf_pkg::ROWS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  nfsf_pkg::in_t                    in_data,
  output logic                             out_valid,
  output nfsf_pkg::out_t                   out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [nfsf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [nfsf_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int SLOTS = COLUMNS * ROWS;
  localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int COL_W = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int FT_W  = $clog2(SLOTS + 1);
  localparam int PW    = nfsf_pkg::PITCH_W;
  localparam int OW    = nfsf_pkg::OFFSET_W;
  // Widest slot center in each axis.
  localparam int CX_W  = $clog2(8191 + (COLUMNS - 1) * 4095 + 1);
  localparam int CZ_W  = $clog2(8191 + (ROWS - 1) * 4095 + 1);
  localparam int CW0   = (CX_W > CZ_W) ? CX_W : CZ_W;
  localparam int CW    = (CW0 > nfsf_pkg::POS_W) ? CW0 : nfsf_pkg::POS_W;
  localparam int DW    = CW + 2;  // signed difference; also distance width

  typedef enum logic [5:0] {
    ST_CLEAR  = 6'b000001,
    ST_IDLE   = 6'b000010,
    ST_SCAN   = 6'b000100,
    ST_FRD    = 6'b001000,
    ST_FWR    = 6'b010000,
    ST_REPORT = 6'b100000
  } state_t;

  // state and control
  state_t              state_r, state_nxt;
  logic [SW-1:0]       clr_r, clr_nxt;
  logic                last_req_r, last_req_nxt;
  logic signed [15:0]  px_r, px_nxt;
  logic signed [15:0]  pz_r, pz_nxt;
  logic                commit_r, commit_nxt;

  // configuration
  logic [PW-1:0]       cpitch_r, cpitch_nxt;
  logic [OW-1:0]       coff_r, coff_nxt;
  logic [PW-1:0]       rpitch_r, rpitch_nxt;
  logic [OW-1:0]       roff_r, roff_nxt;

  // scan issue stage
  logic                iss_on_r, iss_on_nxt;
  logic [COL_W-1:0]    iss_col_r, iss_col_nxt;
  logic [ROW_W-1:0]    iss_row_r, iss_row_nxt;
  logic [SW-1:0]       iss_idx_r, iss_idx_nxt;
  logic [CX_W-1:0]     iss_cx_r, iss_cx_nxt;
  logic [CZ_W-1:0]     iss_cz_r, iss_cz_nxt;

  // scan compare stage, aligned with RAM read data
  logic                p_vld_r, p_vld_nxt;
  logic                p_last_r, p_last_nxt;
  logic [COL_W-1:0]    p_col_r, p_col_nxt;
  logic [ROW_W-1:0]    p_row_r, p_row_nxt;
  logic [SW-1:0]       p_idx_r, p_idx_nxt;
  logic [CX_W-1:0]     p_cx_r, p_cx_nxt;
  logic [CZ_W-1:0]     p_cz_r, p_cz_nxt;

  // running best
  logic                have_r, have_nxt;
  logic [DW-1:0]       best_r, best_nxt;
  logic [SW-1:0]       best_idx_r, best_idx_nxt;
  logic [COL_W-1:0]    best_col_r, best_col_nxt;
  logic [ROW_W-1:0]    best_row_r, best_row_nxt;

  // latched slot and free count
  logic                lat_vld_r, lat_vld_nxt;
  logic [SW-1:0]       lat_idx_r, lat_idx_nxt;
  logic [COL_W-1:0]    lat_col_r, lat_col_nxt;
  logic [ROW_W-1:0]    lat_row_r, lat_row_nxt;
  logic [FT_W-1:0]     free_tot_r, free_tot_nxt;

  logic                out_valid_r, out_valid_nxt;
  nfsf_pkg::out_t      out_r, out_nxt;

  // RAM port
  logic                ram_we;
  logic [SW-1:0]       ram_waddr;
  logic                ram_wdata;
  logic [SW-1:0]       ram_raddr;
  logic                ram_rdata;

  // datapath
  logic                accept;
  logic                rising, falling;
  logic                iss_col_last, iss_row_last;
  logic signed [DW-1:0] dx, dz, ndx, ndz;
  logic [DW-2:0]       ax, az;
  logic [DW-1:0]       man_dist;
  logic                better;
  logic [COL_W+PW-1:0] prod_x;
  logic [ROW_W+PW-1:0] prod_z;
  logic [CX_W-1:0]     rep_cx;
  logic [CZ_W-1:0]     rep_cz;
  logic [31:0]         col_w32, row_w32, idx_w32, ft_w32;

  nfsf_ram #(
    .WIDTH (1),
    .DEPTH (SLOTS)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign busy      = (state_r != ST_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign rising  = in_data.request && !last_req_r;
  assign falling = !in_data.request && last_req_r;

  assign iss_col_last = (iss_col_r == COL_W'(COLUMNS - 1));
  assign iss_row_last = (iss_row_r == ROW_W'(ROWS - 1));

  // Manhattan distance of the slot whose map bit is arriving now.
  always_comb begin
    dx       = $signed(DW'(px_r)) - $signed(DW'(p_cx_r));
    dz       = $signed(DW'(pz_r)) - $signed(DW'(p_cz_r));
    ndx      = -dx;
    ndz      = -dz;
    ax       = dx[DW-1] ? ndx[DW-2:0] : dx[DW-2:0];
    az       = dz[DW-1] ? ndz[DW-2:0] : dz[DW-2:0];
    man_dist = DW'(ax) + DW'(az);
  end

  // strict less keeps the earliest slot on a tie
  assign better = p_vld_r && ram_rdata && (!have_r || (man_dist < best_r));

  // Center of the latched slot under the current configuration.
  always_comb begin
    prod_x  = (COL_W+PW)'(lat_col_r) * (COL_W+PW)'(cpitch_r);
    prod_z  = (ROW_W+PW)'(lat_row_r) * (ROW_W+PW)'(rpitch_r);
    rep_cx  = CX_W'(coff_r) + CX_W'(prod_x);
    rep_cz  = CZ_W'(roff_r) + CZ_W'(prod_z);
    col_w32 = 32'(lat_col_r);
    row_w32 = 32'(lat_row_r);
    idx_w32 = 32'(lat_idx_r);
    ft_w32  = 32'(free_tot_r);
  end

  // RAM access: sweep, scan read, commit read-modify-write.
  always_comb begin
    ram_raddr = (state_r == ST_SCAN) ? iss_idx_r : lat_idx_r;
    ram_we    = 1'b0;
    ram_waddr = lat_idx_r;
    ram_wdata = commit_r;
    if (state_r == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_r;
      ram_wdata = 1'b1;
    end else if (state_r == ST_FWR && ram_rdata != commit_r) begin
      ram_we = 1'b1;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    last_req_nxt  = last_req_r;
    px_nxt        = px_r;
    pz_nxt        = pz_r;
    commit_nxt    = commit_r;
    cpitch_nxt    = cpitch_r;
    coff_nxt      = coff_r;
    rpitch_nxt    = rpitch_r;
    roff_nxt      = roff_r;
    iss_on_nxt    = iss_on_r;
    iss_col_nxt   = iss_col_r;
    iss_row_nxt   = iss_row_r;
    iss_idx_nxt   = iss_idx_r;
    iss_cx_nxt    = iss_cx_r;
    iss_cz_nxt    = iss_cz_r;
    p_vld_nxt     = 1'b0;
    p_last_nxt    = p_last_r;
    p_col_nxt     = p_col_r;
    p_row_nxt     = p_row_r;
    p_idx_nxt     = p_idx_r;
    p_cx_nxt      = p_cx_r;
    p_cz_nxt      = p_cz_r;
    have_nxt      = have_r;
    best_nxt      = best_r;
    best_idx_nxt  = best_idx_r;
    best_col_nxt  = best_col_r;
    best_row_nxt  = best_row_r;
    lat_vld_nxt   = lat_vld_r;
    lat_idx_nxt   = lat_idx_r;
    lat_col_nxt   = lat_col_r;
    lat_row_nxt   = lat_row_r;
    free_tot_nxt  = free_tot_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;

    // the user must issue config writes only while idle; the block does not enforce it
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        nfsf_pkg::REG_COLUMN_PITCH:  cpitch_nxt = cfg_data[PW-1:0];
        nfsf_pkg::REG_COLUMN_OFFSET: coff_nxt   = cfg_data[OW-1:0];
        nfsf_pkg::REG_ROW_PITCH:     rpitch_nxt = cfg_data[PW-1:0];
        nfsf_pkg::REG_ROW_OFFSET:    roff_nxt   = cfg_data[OW-1:0];
        default: ;
      endcase
    end

    unique case (state_r)
      ST_CLEAR: begin
        clr_nxt = SW'(clr_r + 1'b1);
        if (clr_r == SW'(SLOTS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (accept) begin
          last_req_nxt = in_data.request;
          px_nxt       = in_data.pos_x_mm;
          pz_nxt       = in_data.pos_z_mm;
          commit_nxt   = in_data.commit_free;
          if (rising) begin
            state_nxt   = ST_SCAN;
            iss_on_nxt  = 1'b1;
            iss_col_nxt = '0;
            iss_row_nxt = '0;
            iss_idx_nxt = '0;
            iss_cx_nxt  = CX_W'(coff_r);
            iss_cz_nxt  = CZ_W'(roff_r);
            have_nxt    = 1'b0;
          end else if (falling && lat_vld_r) begin
            state_nxt = ST_FRD;
          end else begin
            state_nxt = ST_REPORT;
          end
        end
      end

      ST_SCAN: begin
        // issue one map read per cycle, walking row-major
        if (iss_on_r) begin
          p_vld_nxt  = 1'b1;
          p_last_nxt = iss_col_last && iss_row_last;
          p_col_nxt  = iss_col_r;
          p_row_nxt  = iss_row_r;
          p_idx_nxt  = iss_idx_r;
          p_cx_nxt   = iss_cx_r;
          p_cz_nxt   = iss_cz_r;
          iss_idx_nxt = SW'(iss_idx_r + 1'b1);
          if (iss_col_last) begin
            iss_col_nxt = '0;
            iss_cx_nxt  = CX_W'(coff_r);
            iss_row_nxt = ROW_W'(iss_row_r + 1'b1);
            iss_cz_nxt  = CZ_W'(iss_cz_r + CZ_W'(rpitch_r));
            if (iss_row_last) begin
              iss_on_nxt = 1'b0;
            end
          end else begin
            iss_col_nxt = COL_W'(iss_col_r + 1'b1);
            iss_cx_nxt  = CX_W'(iss_cx_r + CX_W'(cpitch_r));
          end
        end
        // compare the slot whose map bit has arrived
        if (better) begin
          have_nxt     = 1'b1;
          best_nxt     = man_dist;
          best_idx_nxt = p_idx_r;
          best_col_nxt = p_col_r;
          best_row_nxt = p_row_r;
        end
        if (p_vld_r && p_last_r) begin
          state_nxt   = ST_REPORT;
          lat_vld_nxt = have_nxt;
          lat_idx_nxt = have_nxt ? best_idx_nxt : '0;
          lat_col_nxt = have_nxt ? best_col_nxt : '0;
          lat_row_nxt = have_nxt ? best_row_nxt : '0;
        end
      end

      ST_FRD: begin
        state_nxt = ST_FWR;
      end

      ST_FWR: begin
        // map bit of the latched slot is on ram_rdata now
        if (ram_rdata != commit_r) begin
          if (commit_r) begin
            free_tot_nxt = FT_W'(free_tot_r + 1'b1);
          end else if (free_tot_r != '0) begin
            free_tot_nxt = FT_W'(free_tot_r - 1'b1);
          end
        end
        state_nxt = ST_REPORT;
      end

      ST_REPORT: begin
        out_valid_nxt          = 1'b1;
        out_nxt.found          = lat_vld_r;
        out_nxt.slot_column    = lat_vld_r ? col_w32[3:0] : 4'd0;
        out_nxt.slot_row       = lat_vld_r ? row_w32[2:0] : 3'd0;
        out_nxt.slot_index     = lat_vld_r ? idx_w32[5:0] : 6'd0;
        out_nxt.centre_x_mm    = !lat_vld_r ? 16'd0 :
                                 (32'(rep_cx) > nfsf_pkg::CENTRE_MAX) ? 16'hFFFF :
                                 16'(rep_cx);
        out_nxt.centre_z_mm    = !lat_vld_r ? 16'd0 :
                                 (32'(rep_cz) > nfsf_pkg::CENTRE_MAX) ? 16'hFFFF :
                                 16'(rep_cz);
        out_nxt.free_count     = ft_w32[5:0];
        state_nxt              = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      last_req_r  <= 1'b0;
      cpitch_r    <= nfsf_pkg::COLUMN_PITCH_RST;
      coff_r      <= nfsf_pkg::COLUMN_OFFSET_RST;
      rpitch_r    <= nfsf_pkg::ROW_PITCH_RST;
      roff_r      <= nfsf_pkg::ROW_OFFSET_RST;
      iss_on_r    <= 1'b0;
      p_vld_r     <= 1'b0;
      have_r      <= 1'b0;
      lat_vld_r   <= 1'b0;
      lat_idx_r   <= '0;
      lat_col_r   <= '0;
      lat_row_r   <= '0;
      free_tot_r  <= FT_W'(SLOTS);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      last_req_r  <= last_req_nxt;
      cpitch_r    <= cpitch_nxt;
      coff_r      <= coff_nxt;
      rpitch_r    <= rpitch_nxt;
      roff_r      <= roff_nxt;
      iss_on_r    <= iss_on_nxt;
      p_vld_r     <= p_vld_nxt;
      have_r      <= have_nxt;
      lat_vld_r   <= lat_vld_nxt;
      lat_idx_r   <= lat_idx_nxt;
      lat_col_r   <= lat_col_nxt;
      lat_row_r   <= lat_row_nxt;
      free_tot_r  <= free_tot_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    px_r       <= px_nxt;
    pz_r       <= pz_nxt;
    commit_r   <= commit_nxt;
    iss_col_r  <= iss_col_nxt;
    iss_row_r  <= iss_row_nxt;
    iss_idx_r  <= iss_idx_nxt;
    iss_cx_r   <= iss_cx_nxt;
    iss_cz_r   <= iss_cz_nxt;
    p_last_r   <= p_last_nxt;
    p_col_r    <= p_col_nxt;
    p_row_r    <= p_row_nxt;
    p_idx_r    <= p_idx_nxt;
    p_cx_r     <= p_cx_nxt;
    p_cz_r     <= p_cz_nxt;
    best_r     <= best_nxt;
    best_idx_r <= best_idx_nxt;
    best_col_r <= best_col_nxt;
    best_row_r <= best_row_nxt;
    out_r      <= out_nxt;
  end

  // a result strobe only ever follows the report step
  `NFSF_ASSERT_NOW(a_out_after_report, clk, rst_n, out_valid_r, $past(state_r == ST_REPORT))
  // every accepted transfer makes the block busy
  `NFSF_ASSERT_NEXT(a_accept_busy, clk, rst_n, accept, busy)
  // free count never exceeds the map size
  `NFSF_ASSERT_NOW(a_free_bound, clk, rst_n, 1'b1, free_tot_r <= FT_W'(SLOTS))
  // map writes outside the sweep only hit the latched slot
  `NFSF_ASSERT_NOW(a_write_latched, clk, rst_n, ram_we && state_r != ST_CLEAR,
                   state_r == ST_FWR && lat_vld_r && ram_waddr == lat_idx_r)

endmodule

// ----- dv/nearest_free_slot_finder_test.sv -----
// Self-checking testbench for the nearest free slot finder: scans, claims, rack geometry.
`timescale 1ns / 1ps

module nearest_free_slot_finder_test;
  import nfsf_pkg::*;

  localparam int COLUMNS     = COLUMNS_DEF;
  localparam int ROWS        = ROWS_DEF;
  localparam int SLOTS       = COLUMNS * ROWS;
  localparam int STALL_LIMIT = 2000;   // well above a rising scan and the reset sweep
  localparam int DRAIN_WAIT  = 80;     // covers one full rising-edge scan
  localparam int REPORT_MAX  = 10;
  localparam int IDLE_PCT    = 16;

  // Index range beyond the last real register; writes there must be dropped.
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_UNUSED = REG_ROW_OFFSET + 1'b1;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  start     = 1'b0;
  logic                  busy;
  in_t                   in_data   = '0;
  logic                  out_valid;
  out_t                  out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  nearest_free_slot_finder DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------
  // Rack model: geometry registers, free map and the latched pick.
  // ---------------------------------------------------------------------
  logic [PITCH_W-1:0]  geo_col_pitch  = COLUMN_PITCH_RST;
  logic [OFFSET_W-1:0] geo_col_offset = COLUMN_OFFSET_RST;
  logic [PITCH_W-1:0]  geo_row_pitch  = ROW_PITCH_RST;
  logic [OFFSET_W-1:0] geo_row_offset = ROW_OFFSET_RST;

  bit [SLOTS-1:0] rack_free    = '1;
  bit             prev_request = 1'b0;
  bit             held_valid   = 1'b0;
  int             held_slot    = 0;
  int             free_slots   = SLOTS;

  in_t  pending[$];       // scans waiting for the driver
  out_t results_due[$];   // predicted reports, oldest first

  bit gen_req = 1'b0;     // request level of the last queued scan
  bit steady  = 1'b0;     // suppresses driver idling

  int mismatches    = 0;
  int scans_checked = 0;
  int claims        = 0;
  int misses        = 0;
  int reg_writes    = 0;
  int stall_cycles  = 0;

  // One scan of the rack: edge detect, search on rise, commit on fall.
  function automatic out_t scan_rack(input in_t item);
    out_t   res;
    bit     rising;
    bit     falling;
    longint px;
    longint pz;
    longint cx;
    longint cz;
    longint gap;
    longint best;
    int     hit;
    int     slot;
    int     col;
    int     row;
    res     = '0;
    rising  = item.request && !prev_request;
    falling = !item.request && prev_request;
    prev_request = item.request;
    px = longint'($signed(item.pos_x_mm));
    pz = longint'($signed(item.pos_z_mm));

    if (rising) begin
      // Row-major walk; strict less-than keeps the first slot on a tie.
      hit  = -1;
      best = 0;
      for (row = 0; row < ROWS; row++) begin
        for (col = 0; col < COLUMNS; col++) begin
          slot = row * COLUMNS + col;
          if (rack_free[slot]) begin
            cx  = longint'(geo_col_offset) + longint'(col) * longint'(geo_col_pitch);
            cz  = longint'(geo_row_offset) + longint'(row) * longint'(geo_row_pitch);
            gap = (px > cx ? px - cx : cx - px) + (pz > cz ? pz - cz : cz - pz);
            if (hit < 0 || gap < best) begin
              hit  = slot;
              best = gap;
            end
          end
        end
      end
      held_valid = (hit >= 0);
      held_slot  = held_valid ? hit : 0;
    end

    // Falling edge with nothing latched leaves the map alone; rewriting
    // the same value leaves the count alone.
    if (falling && held_valid && rack_free[held_slot] != item.commit_free) begin
      rack_free[held_slot] = item.commit_free;
      if (item.commit_free) begin
        free_slots++;
      end else begin
        free_slots--;
        claims++;
      end
    end

    if (held_valid) begin
      col = held_slot % COLUMNS;
      row = held_slot / COLUMNS;
      cx  = longint'(geo_col_offset) + longint'(col) * longint'(geo_col_pitch);
      cz  = longint'(geo_row_offset) + longint'(row) * longint'(geo_row_pitch);
      res.found       = 1'b1;
      res.slot_column = 4'(col);
      res.slot_row    = 3'(row);
      res.slot_index  = 6'(held_slot);
      res.centre_x_mm = (cx > longint'(CENTRE_MAX)) ? 16'(CENTRE_MAX) : 16'(cx);
      res.centre_z_mm = (cz > longint'(CENTRE_MAX)) ? 16'(CENTRE_MAX) : 16'(cz);
    end
    res.free_count = 6'(free_slots);
    return res;
  endfunction

  // Register writes land in the model as they transfer; only done when idle.
  always @(posedge clk) begin
    if (rst_n && cfg_valid && cfg_ready) begin
      reg_writes++;
      case (cfg_index)
        REG_COLUMN_PITCH:  geo_col_pitch  = cfg_data[PITCH_W-1:0];
        REG_COLUMN_OFFSET: geo_col_offset = cfg_data[OFFSET_W-1:0];
        REG_ROW_PITCH:     geo_row_pitch  = cfg_data[PITCH_W-1:0];
        REG_ROW_OFFSET:    geo_row_offset = cfg_data[OFFSET_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Driver: presents queued scans on start/busy, predicts at each transfer.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        results_due.push_back(scan_rack(in_data));
      end
      // Slot is open when nothing is shown or the shown scan just went in.
      if (!start || !busy) begin
        if (pending.size() != 0 && (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
          start   <= 1'b1;
          in_data <= pending.pop_front();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: one-cycle result strobe, compared against the oldest prediction.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : check_result
    out_t want;
    if (rst_n && out_valid) begin
      scans_checked++;
      if (results_due.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("unexpected report: found %0b idx %0d free %0d",
                   out_data.found, out_data.slot_index, out_data.free_count);
      end else begin
        want = results_due.pop_front();
        if (!want.found) misses++;
        if (out_data.found !== want.found || out_data.slot_column !== want.slot_column ||
            out_data.slot_row !== want.slot_row ||
            out_data.slot_index !== want.slot_index ||
            out_data.centre_x_mm !== want.centre_x_mm ||
            out_data.centre_z_mm !== want.centre_z_mm ||
            out_data.free_count !== want.free_count) begin
          mismatches++;
          if (mismatches <= REPORT_MAX) begin
            $display("scan %0d expected: found %0b col %0d row %0d idx %0d cx %0d cz %0d free %0d",
                     scans_checked, want.found, want.slot_column, want.slot_row,
                     want.slot_index, want.centre_x_mm, want.centre_z_mm, want.free_count);
            $display("scan %0d actual:   found %0b col %0d row %0d idx %0d cx %0d cz %0d free %0d",
                     scans_checked, out_data.found, out_data.slot_column, out_data.slot_row,
                     out_data.slot_index, out_data.centre_x_mm, out_data.centre_z_mm,
                     out_data.free_count);
          end
        end
      end
    end
  end

  // Watchdog: any transfer on any channel counts as progress.
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == STALL_LIMIT) begin
      $display("no transfer for %0d cycles", STALL_LIMIT);
      $display("nearest_free_slot_finder verification failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------
  task automatic push_item(input bit req, input logic signed [POS_W-1:0] x,
                           input logic signed [POS_W-1:0] z, input bit commit);
    in_t item;
    item.request     = req;
    item.pos_x_mm    = x;
    item.pos_z_mm    = z;
    item.commit_free = commit;
    pending.push_back(item);
    gen_req = req;
  endtask

  // Mostly positions around the rack, some anywhere in the 16-bit range.
  function automatic logic signed [POS_W-1:0] pick_mm(input longint far_centre);
    longint lim;
    lim = (far_centre + 2000 > 33767) ? 33767 : far_centre + 2000;
    if ($urandom_range(0, 99) < 70)
      return POS_W'(longint'($urandom_range(0, int'(lim))) - 1000);
    return POS_W'($urandom);
  endfunction

  function automatic logic signed [POS_W-1:0] pick_x();
    return pick_mm(longint'(geo_col_offset) + (COLUMNS - 1) * longint'(geo_col_pitch));
  endfunction

  function automatic logic signed [POS_W-1:0] pick_z();
    return pick_mm(longint'(geo_row_offset) + (ROWS - 1) * longint'(geo_row_pitch));
  endfunction

  // Mostly rise / optional hold / fall transfers with random content,
  // the rest single scans at a random level.
  task automatic add_random(input int count, input int claim_pct);
    int made;
    made = 0;
    while (made < count) begin
      if ($urandom_range(0, 99) < 85) begin
        if (gen_req) begin
          push_item(1'b0, pick_x(), pick_z(), 1'($urandom_range(0, 1)));
          made++;
        end
        push_item(1'b1, pick_x(), pick_z(), 1'($urandom_range(0, 1)));
        made++;
        while ($urandom_range(0, 99) < 20) begin
          push_item(1'b1, pick_x(), pick_z(), 1'($urandom_range(0, 1)));
          made++;
        end
        push_item(1'b0, pick_x(), pick_z(), $urandom_range(0, 99) >= claim_pct);
        made++;
      end else begin
        push_item(1'($urandom_range(0, 1)), pick_x(), pick_z(), 1'($urandom_range(0, 1)));
        made++;
      end
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // All four geometry registers, then a write to an index that must be ignored.
  task automatic program_rack(input logic [CFG_DATA_W-1:0] cp, input logic [CFG_DATA_W-1:0] co,
                              input logic [CFG_DATA_W-1:0] rp, input logic [CFG_DATA_W-1:0] ro);
    write_reg(REG_COLUMN_PITCH, cp);
    write_reg(REG_COLUMN_OFFSET, co);
    write_reg(REG_ROW_PITCH, rp);
    write_reg(REG_ROW_OFFSET, ro);
    write_reg(CFG_IDX_W'($urandom_range(int'(REG_FIRST_UNUSED), 255)), CFG_DATA_W'($urandom));
    cfg_valid <= 1'b0;
  endtask

  // Idle: every queued scan transferred, every report back, block not busy.
  task automatic settle();
    do @(posedge clk);
    while (pending.size() != 0 || start || results_due.size() != 0 || busy);
  endtask

  // ---------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------
  initial begin
    int n;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);
    settle();   // clearing sweep of the map after reset

    // Reset geometry: extremes of the position, same-value commit, claims at
    // the far corner, a scan right on a slot center, held levels.
    push_item(1'b0, -32768, 32767, 1'b1);   // low level, nothing latched yet
    push_item(1'b1, -32768, -32768, 1'b0);  // rise, corner -> slot 0
    push_item(1'b1, 32767, 32767, 1'b0);    // held high, no new search
    push_item(1'b0, 0, 0, 1'b1);            // fall, rewrite free: count unchanged
    push_item(1'b1, 32767, 32767, 1'b1);    // rise -> last slot
    push_item(1'b0, 5000, 5000, 1'b0);      // claim it
    push_item(1'b1, 32767, 32767, 1'b0);    // next nearest to the corner
    push_item(1'b0, -1, -1, 1'b0);          // claim it too
    push_item(1'b1, 1435, 550, 1'b1);       // exactly on slot 0 center
    push_item(1'b0, 32767, -32768, 1'b1);
    push_item(1'b0, -32768, 32767, 1'b0);   // held low
    add_random(200, 6);
    settle();

    // Round geometry so exact ties exist: first slot in scan order must win.
    program_rack(16'd1000, 16'd0, 16'd1000, 16'd0);
    push_item(1'b1, 500, 0, 1'b1);          // tie between two columns
    push_item(1'b0, 500, 0, 1'b1);
    push_item(1'b1, 500, 500, 1'b1);        // four-way tie
    push_item(1'b0, 0, 0, 1'b1);
    add_random(150, 6);
    settle();

    // All-ones data: masks to the largest pitches and offsets.
    // This phase also runs without driver idling.
    program_rack(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    steady = 1'b1;
    push_item(1'b1, 32767, 32767, 1'b1);
    push_item(1'b0, -32768, -32768, 1'b0);
    add_random(150, 6);
    settle();
    steady = 1'b0;

    // Only bits above the register widths set: zero pitches and offsets, so
    // every center sits at the origin and scan order alone decides.
    program_rack(16'hF000, 16'hE000, 16'hF000, 16'hE000);
    push_item(1'b1, 123, -456, 1'b0);
    push_item(1'b0, 123, -456, 1'b0);       // claim the first free slot
    push_item(1'b1, -32768, 32767, 1'b1);   // next one in scan order
    push_item(1'b0, 0, 0, 1'b1);
    add_random(150, 6);
    settle();

    // Random geometry, heavier claiming, then fill the rack completely and
    // keep scanning so searches come back empty.
    program_rack(CFG_DATA_W'($urandom_range(1, 4095)), CFG_DATA_W'($urandom_range(0, 8191)),
                 CFG_DATA_W'($urandom_range(1, 4095)), CFG_DATA_W'($urandom_range(0, 8191)));
    add_random(120, 30);
    for (n = 0; n < SLOTS + 6; n++) begin
      push_item(1'b1, pick_x(), pick_z(), 1'($urandom_range(0, 1)));
      push_item(1'b0, pick_x(), pick_z(), 1'b0);
    end
    add_random(40, 30);
    settle();
    repeat (DRAIN_WAIT) @(posedge clk);

    if (results_due.size() != 0) begin
      $display("%0d predicted reports never arrived", results_due.size());
      mismatches += results_due.size();
    end
    $display("covered %0d scans, %0d slot claims, %0d scans with no free slot latched,",
             scans_checked, claims, misses);
    $display("%0d register writes over five rack geometries, %0d mismatches",
             reg_writes, mismatches);
    if (mismatches == 0) begin
      $display("nearest_free_slot_finder verification clean");
    end else begin
      $display("nearest_free_slot_finder verification failed");
    end
    $finish;
  end

endmodule

// ----- nearest_free_slot_finder.f -----
+incdir+rtl
rtl/nfsf_pkg.sv
rtl/nfsf_ram.sv
rtl/nearest_free_slot_finder.sv
dv/nearest_free_slot_finder_test.sv
